FILE: sv/bim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bim_pkg
// Widths, register indexes and the item record of the broadcast index mapper.
// ----------------------------------------------------------------------------
package bim_pkg;

	localparam int INDEX_W      = 32;
	localparam int SIZE_W       = 16;
	localparam int OFS_W        = 36;
	localparam int BPE_W        = 5;
	localparam int RANK_W       = 3;
	localparam int MASK_W       = 4;
	localparam int REG_IDX_W    = 3;
	localparam int CFG_W        = 16;
	localparam int MAX_AXES_DEF = 4;

	// one division cell per quotient bit, then two cells of stride work
	localparam int AXIS_LAT = INDEX_W + 2;

	localparam logic [REG_IDX_W-1:0] REG_ACTIVE_RANK       = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_TARGET_SIZE0      = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_TARGET_SIZE1      = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_TARGET_SIZE2      = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TARGET_SIZE3      = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_BROADCAST_MASK    = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_BYTES_PER_ELEMENT = 3'd6;

	typedef struct packed {
		logic               valid;
		logic [INDEX_W-1:0] dest;
		logic [INDEX_W-1:0] num;
		logic [SIZE_W-1:0]  rem;
		logic [INDEX_W-1:0] src;
		logic [INDEX_W-1:0] stride;
		logic [INDEX_W-1:0] prod;
		logic               oor;
	} item_t;

endpackage

FILE: sv/bim_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bim_div_cell
// One restoring division step: shift in a dividend bit, subtract if it fits.
// ----------------------------------------------------------------------------
module bim_div_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [bim_pkg::SIZE_W-1:0] divisor,
	input  bim_pkg::item_t            item_in,
	output bim_pkg::item_t            item_out
);
	import bim_pkg::*;

	logic [SIZE_W:0] trial;
	logic [SIZE_W:0] diff;
	logic            fits;
	item_t           nxt;
	item_t           item_s1;

	always_comb begin
		trial = {item_in.rem, item_in.num[INDEX_W-1]};
		diff  = trial - {1'b0, divisor};
		fits  = trial >= {1'b0, divisor};
		nxt   = item_in;
		nxt.rem = fits ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
		nxt.num = {item_in.num[INDEX_W-2:0], fits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else begin
			item_s1 <= nxt;
		end
	end

	assign item_out = item_s1;

endmodule

FILE: sv/bim_axis_tail.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bim_axis_tail
// Weight coordinate by source stride, advance it, add; not on broadcast axes.
// ----------------------------------------------------------------------------
module bim_axis_tail (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [bim_pkg::SIZE_W-1:0] divisor,
	input  logic                      bcast,
	input  bim_pkg::item_t            item_in,
	output bim_pkg::item_t            item_out
);
	import bim_pkg::*;

	item_t item_s1;
	item_t item_s2;
	item_t nxt_a;
	item_t nxt_b;

	always_comb begin
		nxt_a = item_in;
		nxt_a.prod   = bcast ? '0 : INDEX_W'({{(INDEX_W-SIZE_W){1'b0}}, item_in.rem} *
			item_in.stride);
		nxt_a.stride = bcast ? item_in.stride :
			INDEX_W'({{(INDEX_W-SIZE_W){1'b0}}, divisor} * item_in.stride);
		nxt_a.rem    = '0;
		nxt_b = item_s1;
		nxt_b.src  = item_s1.src + item_s1.prod;
		nxt_b.prod = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
			item_s2 <= '0;
		end else begin
			item_s1 <= nxt_a;
			item_s2 <= nxt_b;
		end
	end

	assign item_out = item_s2;

endmodule

FILE: sv/bim_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bim_axis
// One axis: a row of division cells splitting off the coordinate, then a tail.
// ----------------------------------------------------------------------------
module bim_axis (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [bim_pkg::SIZE_W-1:0] divisor,
	input  logic                      bcast,
	input  bim_pkg::item_t            item_in,
	output bim_pkg::item_t            item_out
);
	import bim_pkg::*;

	item_t step_w [INDEX_W+1];

	assign step_w[0] = item_in;

	for (genvar i = 0; i < INDEX_W; i++) begin : g_cell
		bim_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.divisor  (divisor),
			.item_in  (step_w[i]),
			.item_out (step_w[i+1])
		);
	end

	bim_axis_tail u_tail (
		.clk      (clk),
		.arst_n   (arst_n),
		.divisor  (divisor),
		.bcast    (bcast),
		.item_in  (step_w[INDEX_W]),
		.item_out (item_out)
	);

endmodule

FILE: sv/broadcast_index_mapper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// broadcast_index_mapper_core
// Maps a destination element index of a broadcast tensor to its source index.
// ----------------------------------------------------------------------------
// Usage:
//   Load the shape through cfg_write/cfg_index/cfg_data while no item is in
//   flight. Present dest_index with start high; busy is always low, so an
//   item is taken at every clock edge where start is high.
//   Each item moves through MAX_AXES axis sections. A section is a row of 32
//   division cells (one quotient bit each) followed by two stride cells; a
//   result register follows the last section. Throughput is one item per cycle.
//   The result (source_index, both byte offsets, out_of_range) is shown for
//   one cycle with done high; the receiver cannot stall it.
//   Reset clears the pipeline and loads rank 1, all extents 1, no broadcast
//   axes and 4 bytes per element.
// ----------------------------------------------------------------------------
module broadcast_index_mapper_core #(
	parameter int MAX_AXES = bim_pkg::MAX_AXES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [bim_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [bim_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          start,
	output logic                          busy,
	input  logic [bim_pkg::INDEX_W-1:0]   dest_index,
	output logic                          done,
	output logic [bim_pkg::INDEX_W-1:0]   source_index,
	output logic [bim_pkg::OFS_W-1:0]     source_byte_offset,
	output logic [bim_pkg::OFS_W-1:0]     dest_byte_offset,
	output logic                          out_of_range
);
	import bim_pkg::*;

	localparam int LATENCY = MAX_AXES * AXIS_LAT + 1;

	logic [RANK_W-1:0] active_rank_q;
	logic [SIZE_W-1:0] size_q [MAX_AXES];
	logic [MASK_W-1:0] bcast_q;
	logic [BPE_W-1:0]  bpe_q;

	logic [RANK_W-1:0]   rank_eff;
	logic [SIZE_W-1:0]   div_w [MAX_AXES];
	logic                bc_w [MAX_AXES];
	logic [MAX_AXES-1:0] zero_w;

	item_t head_w;
	item_t chain_w [MAX_AXES+1];
	item_t last_w;
	logic               oor_f;
	logic [INDEX_W-1:0] src_f;

	logic               done_q;
	logic [INDEX_W-1:0] src_q;
	logic [OFS_W-1:0]   src_ofs_q;
	logic [OFS_W-1:0]   dst_ofs_q;
	logic               oor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_rank_q <= RANK_W'(1);
			bcast_q       <= '0;
			bpe_q         <= BPE_W'(4);
			for (int k = 0; k < MAX_AXES; k++) begin
				size_q[k] <= SIZE_W'(1);
			end
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ACTIVE_RANK: begin
					active_rank_q <= cfg_data[RANK_W-1:0];
				end
				REG_BROADCAST_MASK: begin
					bcast_q <= cfg_data[MASK_W-1:0];
				end
				REG_BYTES_PER_ELEMENT: begin
					bpe_q <= cfg_data[BPE_W-1:0];
				end
				default: begin
					for (int k = 0; k < MAX_AXES; k++) begin
						if (cfg_index == REG_IDX_W'(int'(REG_TARGET_SIZE0) + k)) begin
							size_q[k] <= cfg_data[SIZE_W-1:0];
						end
					end
				end
			endcase
		end
	end

	always_comb begin
		if (active_rank_q == '0) begin
			rank_eff = RANK_W'(1);
		end else if (active_rank_q > RANK_W'(MAX_AXES)) begin
			rank_eff = RANK_W'(MAX_AXES);
		end else begin
			rank_eff = active_rank_q;
		end
		for (int k = 0; k < MAX_AXES; k++) begin
			div_w[k]  = (RANK_W'(k) < rank_eff) ? size_q[k] : SIZE_W'(1);
			bc_w[k]   = (RANK_W'(k) < rank_eff) && bcast_q[k];
			zero_w[k] = (RANK_W'(k) < rank_eff) && (size_q[k] == '0);
		end
	end

	always_comb begin
		head_w        = '0;
		head_w.valid  = start;
		head_w.dest   = dest_index;
		head_w.num    = dest_index;
		head_w.stride = INDEX_W'(1);
		head_w.oor    = |zero_w;
	end

	assign chain_w[0] = head_w;

	for (genvar k = 0; k < MAX_AXES; k++) begin : g_axis
		bim_axis u_axis (
			.clk      (clk),
			.arst_n   (arst_n),
			.divisor  (div_w[k]),
			.bcast    (bc_w[k]),
			.item_in  (chain_w[k]),
			.item_out (chain_w[k+1])
		);
	end

	assign last_w = chain_w[MAX_AXES];
	assign oor_f  = last_w.oor || (last_w.num != '0);
	assign src_f  = oor_f ? '0 : last_w.src;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= last_w.valid;
		end
	end

	always_ff @(posedge clk) begin
		src_q     <= src_f;
		src_ofs_q <= OFS_W'(src_f) * OFS_W'(bpe_q);
		dst_ofs_q <= OFS_W'(last_w.dest) * OFS_W'(bpe_q);
		oor_q     <= oor_f;
	end

	assign busy               = 1'b0;
	assign done               = done_q;
	assign source_index       = src_q;
	assign source_byte_offset = src_ofs_q;
	assign dest_byte_offset   = dst_ofs_q;
	assign out_of_range       = oor_q;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("item taken without result");

	a_no_stray_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without item");

	a_oor_zero_src: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_of_range) |-> (source_index == '0 && source_byte_offset == '0))
		else $error("out of range item carries a source index");

	a_dest_offset: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (dest_byte_offset ==
			OFS_W'(OFS_W'($past(dest_index, LATENCY)) * OFS_W'(bpe_q))))
		else $error("destination offset mismatch");

endmodule

FILE: test/tb_broadcast_index_mapper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_broadcast_index_mapper_core
// Self-checking bench for the broadcast index mapper: a short table of
// directed shapes and indexes, then random shapes with random index streams,
// every result checked against a scoreboard fed by typed-in expectations or a predictor.
// ----------------------------------------------------------------------------
module tb_broadcast_index_mapper_core;

	import bim_pkg::*;

	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [INDEX_W-1:0] src;
		logic [OFS_W-1:0]   src_ofs;
		logic [OFS_W-1:0]   dst_ofs;
		logic               oor;
	} mapping_t;

	typedef struct packed {
		logic                 is_write;
		logic [REG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     data;
		logic [INDEX_W-1:0]   dest;
		logic                 typed;
		mapping_t             want;
	} step_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 start = 1'b0;
	logic [INDEX_W-1:0]   dest_index = '0;
	logic                 busy;
	logic                 done;
	logic [INDEX_W-1:0]   source_index;
	logic [OFS_W-1:0]     source_byte_offset;
	logic [OFS_W-1:0]     dest_byte_offset;
	logic                 out_of_range;

	// sideband that travels with start: a typed-in expectation for the item
	logic     tag_typed = 1'b0;
	mapping_t tag_want = '0;

	// shadow of the shape registers
	logic [RANK_W-1:0] rank_r = 3'd1;
	logic [SIZE_W-1:0] size_r [4] = '{16'd1, 16'd1, 16'd1, 16'd1};
	logic [MASK_W-1:0] mask_r = '0;
	logic [BPE_W-1:0]  bpe_r = 5'd4;

	mapping_t pending_maps[$];
	int       errors = 0;
	int       items_mapped = 0;
	int       oor_seen = 0;
	int       shapes_loaded = 0;

	broadcast_index_mapper_core i_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_write          (cfg_write),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.start              (start),
		.busy               (busy),
		.dest_index         (dest_index),
		.done               (done),
		.source_index       (source_index),
		.source_byte_offset (source_byte_offset),
		.dest_byte_offset   (dest_byte_offset),
		.out_of_range       (out_of_range)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int axes_used();
		if (rank_r == 0) return 1;
		if (rank_r > MAX_AXES_DEF) return MAX_AXES_DEF;
		return int'(rank_r);
	endfunction

	function automatic longint unsigned elem_count();
		longint unsigned cnt;
		cnt = 1;
		for (int k = 0; k < axes_used(); k++) cnt *= size_r[k];
		return cnt;
	endfunction

	function automatic mapping_t map_index(input logic [INDEX_W-1:0] dest);
		longint unsigned rem, stride, acc, sz, coord;
		mapping_t m;
		rem = dest;
		stride = 1;
		acc = 0;
		m.oor = 64'(dest) >= elem_count();
		if (!m.oor) begin
			for (int k = 0; k < axes_used(); k++) begin
				sz = size_r[k];
				coord = rem % sz;
				rem = rem / sz;
				if (!mask_r[k]) begin
					acc += coord * stride;
					stride *= sz;
				end
			end
		end
		m.src = acc[INDEX_W-1:0];
		m.src_ofs = OFS_W'(64'(m.src) * 64'(bpe_r));
		m.dst_ofs = OFS_W'(64'(dest) * 64'(bpe_r));
		return m;
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 3) return '0;
		if (r < 10) return SIZE_W'($urandom_range(65535, 1000));
		return SIZE_W'($urandom_range(12, 1));
	endfunction

	function automatic logic [INDEX_W-1:0] pick_dest();
		longint unsigned cnt;
		int unsigned r;
		cnt = elem_count();
		r = $urandom_range(99);
		if (cnt == 0 || r >= 90) return $urandom;
		if (r >= 85) return r[0] ? 32'hFFFF_FFFF : 32'd0;
		if (r >= 75) begin
			if (cnt > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
			return r[0] ? 32'(cnt - 1) : 32'(cnt);
		end
		if (cnt > 64'hFFFF_FFFF) return $urandom;
		return $urandom_range(32'(cnt - 1), 0);
	endfunction

	function automatic step_t setreg(input logic [REG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] data);
		step_t s;
		s = '0;
		s.is_write = 1'b1;
		s.idx = idx;
		s.data = data;
		return s;
	endfunction

	function automatic step_t probe(input logic [INDEX_W-1:0] dest);
		step_t s;
		s = '0;
		s.dest = dest;
		return s;
	endfunction

	function automatic step_t hit(input logic [INDEX_W-1:0] dest,
			input logic [INDEX_W-1:0] src, input logic [OFS_W-1:0] src_ofs,
			input logic [OFS_W-1:0] dst_ofs, input logic oor);
		step_t s;
		s = '0;
		s.dest = dest;
		s.typed = 1'b1;
		s.want.src = src;
		s.want.src_ofs = src_ofs;
		s.want.dst_ofs = dst_ofs;
		s.want.oor = oor;
		return s;
	endfunction

	task automatic load_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_ACTIVE_RANK:       rank_r = data[RANK_W-1:0];
			REG_TARGET_SIZE0:      size_r[0] = data;
			REG_TARGET_SIZE1:      size_r[1] = data;
			REG_TARGET_SIZE2:      size_r[2] = data;
			REG_TARGET_SIZE3:      size_r[3] = data;
			REG_BROADCAST_MASK:    mask_r = data[MASK_W-1:0];
			REG_BYTES_PER_ELEMENT: bpe_r = data[BPE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic issue(input logic [INDEX_W-1:0] dest, input logic typed,
			input mapping_t want);
		start <= 1'b1;
		dest_index <= dest;
		tag_typed <= typed;
		tag_want <= want;
		cfg_write <= 1'b0;
		do @(posedge clk); while (busy);
	endtask

	// hold the sender until every pending result is out
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (pending_maps.size() != 0);
	endtask

	always @(posedge clk) begin
		mapping_t want;
		if (arst_n) begin
			if (start && !busy) begin
				pending_maps.push_back(tag_typed ? tag_want : map_index(dest_index));
				items_mapped++;
			end
			if (done) begin
				if (pending_maps.size() == 0) begin
					$error("result with no item pending: source_index %h", source_index);
					errors++;
				end else begin
					want = pending_maps.pop_front();
					if (out_of_range) oor_seen++;
					if (source_index !== want.src) begin
						$error("source_index: expected %h, got %h", want.src, source_index);
						errors++;
					end
					if (source_byte_offset !== want.src_ofs) begin
						$error("source_byte_offset: expected %h, got %h", want.src_ofs,
							source_byte_offset);
						errors++;
					end
					if (dest_byte_offset !== want.dst_ofs) begin
						$error("dest_byte_offset: expected %h, got %h", want.dst_ofs,
							dest_byte_offset);
						errors++;
					end
					if (out_of_range !== want.oor) begin
						$error("out_of_range: expected %b, got %b", want.oor, out_of_range);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		#(5_000_000);
		$display("tb_broadcast_index_mapper_core failed");
		$finish;
	end

	initial begin
		step_t             plan[$];
		int                ph, n, k, pct, gap;
		logic [RANK_W-1:0] rank;
		logic [SIZE_W-1:0] sz;
		logic [MASK_W-1:0] bmask;
		logic [BPE_W-1:0]  bpe;

		plan = {
			hit(32'd0, 32'd0, 36'd0, 36'd0, 1'b0),
			hit(32'd1, 32'd0, 36'd0, 36'd4, 1'b1),
			hit(32'hFFFF_FFFF, 32'd0, 36'd0, 36'h3_FFFF_FFFC, 1'b1),
			setreg(REG_ACTIVE_RANK, 16'd4),
			setreg(REG_TARGET_SIZE0, 16'hFFFF),
			setreg(REG_TARGET_SIZE1, 16'hFFFF),
			setreg(REG_TARGET_SIZE2, 16'hFFFF),
			setreg(REG_TARGET_SIZE3, 16'hFFFF),
			setreg(REG_BROADCAST_MASK, 16'd0),
			setreg(REG_BYTES_PER_ELEMENT, 16'd16),
			hit(32'hFFFF_FFFF, 32'hFFFF_FFFF, 36'hF_FFFF_FFF0, 36'hF_FFFF_FFF0, 1'b0),
			hit(32'd0, 32'd0, 36'd0, 36'd0, 1'b0),
			probe(32'h89AB_CDEF),
			setreg(REG_BROADCAST_MASK, 16'hF),
			hit(32'h1234_5678, 32'd0, 36'd0, 36'h1_2345_6780, 1'b0),
			setreg(REG_BYTES_PER_ELEMENT, 16'd0),
			hit(32'hFFFF_FFFF, 32'd0, 36'd0, 36'd0, 1'b0),
			// largest element size, partial broadcast on a 3x5x7 shape
			setreg(REG_BYTES_PER_ELEMENT, 16'd31),
			setreg(REG_BROADCAST_MASK, 16'd5),
			setreg(REG_ACTIVE_RANK, 16'd3),
			setreg(REG_TARGET_SIZE0, 16'd3),
			setreg(REG_TARGET_SIZE1, 16'd5),
			setreg(REG_TARGET_SIZE2, 16'd7),
			probe(32'd0),
			probe(32'd52),
			probe(32'd104),
			probe(32'd105),
			// rank zero acts as one axis
			setreg(REG_ACTIVE_RANK, 16'd0),
			probe(32'd2),
			probe(32'd3),
			// rank above the axis count saturates
			setreg(REG_ACTIVE_RANK, 16'd7),
			probe(32'h00AB_CDEF),
			// mask bits of unused axes
			setreg(REG_ACTIVE_RANK, 16'd1),
			setreg(REG_BROADCAST_MASK, 16'hE),
			probe(32'd2),
			// zero extent: nothing is in range
			setreg(REG_TARGET_SIZE0, 16'd0),
			probe(32'd0),
			setreg(REG_UNUSED, 16'hFFFF),
			probe(32'd1)
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_write) begin
				if (i == 0 || !plan[i-1].is_write) settle();
				load_reg(plan[i].idx, plan[i].data);
			end else begin
				issue(plan[i].dest, plan[i].typed, plan[i].want);
			end
		end

		for (ph = 0; ph < 12; ph++) begin
			pct = (ph % 3 == 1) ? 48 : (ph % 3 == 2) ? 14 : 0;
			settle();
			if (ph == 0) rank = 3'd4;
			else if (ph == 1) rank = 3'd1;
			else if ($urandom_range(9) == 0) rank = RANK_W'($urandom_range(7));
			else rank = RANK_W'($urandom_range(4, 1));
			load_reg(REG_ACTIVE_RANK, {13'($urandom), rank});
			for (k = 0; k < 4; k++) begin
				sz = (ph == 0) ? 16'hFFFF : (ph == 1) ? 16'd1 : pick_size();
				load_reg(REG_TARGET_SIZE0 + REG_IDX_W'(k), sz);
			end
			bmask = (ph == 1) ? '0 : MASK_W'($urandom_range(15));
			load_reg(REG_BROADCAST_MASK, {12'($urandom), bmask});
			bpe = (ph == 0) ? 5'd31 : (ph == 1) ? 5'd1 : (ph == 2) ? 5'd0 :
				BPE_W'($urandom_range(31));
			load_reg(REG_BYTES_PER_ELEMENT, {11'($urandom), bpe});
			if ($urandom_range(3) == 0) load_reg(REG_UNUSED, 16'($urandom));
			shapes_loaded++;

			for (n = 0; n < 120; n++) begin
				if (ph == 4 && n == 60) settle();
				issue(pick_dest(), 1'b0, '0);
				gap = 0;
				while (pct != 0 && $urandom_range(99) < pct) gap++;
				if (gap != 0) begin
					start <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end

		settle();
		repeat (AXIS_LAT * MAX_AXES_DEF + 8) @(posedge clk);

		$display("mapped %0d indexes over %0d random shapes plus the directed table",
			items_mapped, shapes_loaded);
		$display("%0d results flagged out of range", oor_seen);
		if (errors == 0) begin
			$display("tb_broadcast_index_mapper_core passed");
		end else begin
			$display("tb_broadcast_index_mapper_core failed");
		end
		$finish;
	end

endmodule
